[sv/vctc_pkg.sv]
// Shared types, widths and helpers for the viewport crop and triangle cull block.
// Depends on nothing; every other file imports it.
`default_nettype none

package vctc_pkg;

    // Coordinate range that results saturate to (signed bits, capped at the port width)
    localparam int COORD_WIDTH = 32;
    localparam int OUT_W       = 32;
    localparam int SAT_W       = (COORD_WIDTH > OUT_W) ? OUT_W :
                                 ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);

    // Register field widths
    localparam int SZ_W  = 15;
    localparam int ORG_W = 24;
    localparam int MRG_W = 22;
    localparam int CFG_W = 24;
    localparam int IDX_W = 3;

    // Source offset plus one (Q16) and the remap datapath widths
    localparam int ONE_Q16 = 65536;
    localparam int AX_W    = OUT_W + 1;            // X + 1.0, 1.0 - Y
    localparam int MPY_W   = AX_W + SZ_W + 1;      // times source size
    localparam int NUM_W   = 52;                   // 2n + d, signed
    localparam int DEN_W   = SZ_W + 1;             // 2d
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // Cull products: coordinate times crop size
    localparam int PRD_W = OUT_W + SZ_W + 1;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QP_W   = $clog2(QDEPTH);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_SRC_W  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SRC_H  = 3'd1;
    localparam logic [IDX_W-1:0] REG_CROP_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_CROP_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_CROP_W = 3'd4;
    localparam logic [IDX_W-1:0] REG_CROP_H = 3'd5;
    localparam logic [IDX_W-1:0] REG_MARGIN = 3'd6;

    // Vertex slot within a triangle
    localparam logic [1:0] SLOT_FIRST = 2'd0;
    localparam logic [1:0] SLOT_LAST  = 2'd2;

    localparam logic signed [NUM_W:0] SAT_HI =
        (NUM_W+1)'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
    localparam logic signed [NUM_W:0] SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic [SZ_W-1:0]         src_w;
        logic [SZ_W-1:0]         src_h;
        logic signed [ORG_W-1:0] crop_x;
        logic signed [ORG_W-1:0] crop_y;
        logic [SZ_W-1:0]         crop_w;   // never zero
        logic [SZ_W-1:0]         crop_h;   // never zero
        logic [MRG_W-1:0]        margin;
    } t_cfg;

    typedef struct packed {
        logic signed [NUM_W-1:0] nx;       // 2n + d for x
        logic signed [NUM_W-1:0] ny;       // 2n + d for y
        logic [1:0]              slot;
    } t_vtx_num;

    typedef struct packed {
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] x;
    } t_vtx;

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [NUM_W:0] v);
        logic signed [NUM_W:0] r;
        begin
            r = v;
            if (v > SAT_HI) begin
                r = SAT_HI;
            end else if (v < SAT_LO) begin
                r = SAT_LO;
            end
            sat = OUT_W'(r);
        end
    endfunction

endpackage

`default_nettype wire

[sv/viewport_crop_triangle_cull.sv]
// Top level of the viewport crop and triangle cull block: register file, front end,
// numerator queue and back end. Depends on vctc_pkg, vctc_front, vctc_fifo and vctc_back.
//
//  channel  | direction | handshake             | beat
//  ---------+-----------+-----------------------+--------------------------------------
//  vertex   | in        | push / full           | vertex_x, vertex_y, first_of_draw
//  result   | out       | empty / pop           | out_x, out_y, last_of_triangle
//  config   | in        | i_cfg_we (no stall)   | i_cfg_idx, i_cfg_data
//
// Each vertex passes through the back end's bit-serial divider (one quotient bit per
// cycle over 52 bits) with its load, fix-up and saturate steps; the third vertex of a
// triangle also passes through the cull multiply and compare. The front end registers
// each vertex, then its numerators; it stalls once it and the four-entry queue are full.
// Reset (synchronous, active low) restores the register defaults and empties all queues.
// A kept triangle waits in the back end until the previous triangle's beats are popped.
`default_nettype none

module viewport_crop_triangle_cull
    import vctc_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // configuration writes
    input  wire                     i_cfg_we,
    input  wire [IDX_W-1:0]         i_cfg_idx,
    input  wire [CFG_W-1:0]         i_cfg_data,
    // vertex input
    input  wire                     push,
    output logic                    full,
    input  wire signed [OUT_W-1:0]  i_vertex_x,
    input  wire signed [OUT_W-1:0]  i_vertex_y,
    input  wire                     i_first_of_draw,
    // result output
    output logic                    empty,
    input  wire                     pop,
    output logic signed [OUT_W-1:0] o_out_x,
    output logic signed [OUT_W-1:0] o_out_y,
    output logic                    o_last_of_triangle
);

    t_cfg            r_cfg;
    logic [SZ_W-1:0] wr_size;

    logic            q_push, q_full, q_pop, q_empty;
    t_vtx_num        q_wdata, q_rdata;

    // A zero crop size behaves as one pixel: store it that way.
    assign wr_size = (i_cfg_data[SZ_W-1:0] == '0) ? SZ_W'(1) : i_cfg_data[SZ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_w  <= SZ_W'(1);
            r_cfg.src_h  <= SZ_W'(1);
            r_cfg.crop_x <= '0;
            r_cfg.crop_y <= '0;
            r_cfg.crop_w <= SZ_W'(1);
            r_cfg.crop_h <= SZ_W'(1);
            r_cfg.margin <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SRC_W:  r_cfg.src_w  <= i_cfg_data[SZ_W-1:0];
                REG_SRC_H:  r_cfg.src_h  <= i_cfg_data[SZ_W-1:0];
                REG_CROP_X: r_cfg.crop_x <= $signed(i_cfg_data[ORG_W-1:0]);
                REG_CROP_Y: r_cfg.crop_y <= $signed(i_cfg_data[ORG_W-1:0]);
                REG_CROP_W: r_cfg.crop_w <= wr_size;
                REG_CROP_H: r_cfg.crop_h <= wr_size;
                REG_MARGIN: r_cfg.margin <= i_cfg_data[MRG_W-1:0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // Front: accept, tag slot, form numerators.
    vctc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_push          (push),
        .o_full          (full),
        .i_vertex_x      (i_vertex_x),
        .i_vertex_y      (i_vertex_y),
        .i_first_of_draw (i_first_of_draw),
        .o_q_push        (q_push),
        .i_q_full        (q_full),
        .o_q_data        (q_wdata)
    );

    // Decouple the two halves so each can stall on its own.
    vctc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // Back: divide, saturate, group, cull, emit beats.
    vctc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_empty          (q_empty),
        .o_q_pop            (q_pop),
        .i_q_data           (q_rdata),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_out_x            (o_out_x),
        .o_out_y            (o_out_y),
        .o_last_of_triangle (o_last_of_triangle)
    );

endmodule

`default_nettype wire

[sv/vctc_front.sv]
// Front end: accepts vertices, tags each with its triangle slot and forms the
// remap numerators. Depends on vctc_pkg.
`default_nettype none

module vctc_front
    import vctc_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire                    i_push,
    output logic                   o_full,
    input  wire signed [OUT_W-1:0] i_vertex_x,
    input  wire signed [OUT_W-1:0] i_vertex_y,
    input  wire                    i_first_of_draw,
    output logic                   o_q_push,
    input  wire                    i_q_full,
    output t_vtx_num               o_q_data
);

    logic                    r_s1_vld, r_s2_vld;
    logic [1:0]              r_phase;
    logic signed [AX_W-1:0]  r_ax, r_ay;
    logic [1:0]              r_slot1;
    t_vtx_num                r_num;

    logic                    s1_rdy, s2_rdy, acc;
    logic [1:0]              p_cur;
    logic signed [MPY_W-1:0] prod_x, prod_y;
    logic signed [NUM_W-1:0] px, py, cxs, cys, n_nx, n_ny;

    always_comb begin
        s2_rdy = !r_s2_vld || !i_q_full;
        s1_rdy = !r_s1_vld || s2_rdy;
        o_full = !s1_rdy;
        acc    = i_push && s1_rdy;
        // first_of_draw drops any partial triangle
        p_cur  = i_first_of_draw ? SLOT_FIRST : r_phase;
    end

    always_comb begin
        prod_x = r_ax * $signed({1'b0, i_cfg.src_w});
        prod_y = r_ay * $signed({1'b0, i_cfg.src_h});
        px     = NUM_W'(prod_x);
        py     = NUM_W'(prod_y);
        cxs    = NUM_W'(i_cfg.crop_x);
        cys    = NUM_W'(i_cfg.crop_y);
        n_nx   = ((px - (cxs <<< 9)) <<< 1) + $signed(NUM_W'({1'b0, i_cfg.crop_w}));
        n_ny   = ((py - (cys <<< 9)) <<< 1) + $signed(NUM_W'({1'b0, i_cfg.crop_h}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_phase  <= SLOT_FIRST;
        end else begin
            if (acc) begin
                r_phase <= (p_cur == SLOT_LAST) ? SLOT_FIRST : p_cur + 2'd1;
            end
            if (s1_rdy) begin
                r_s1_vld <= i_push;
            end
            if (s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ax    <= AX_W'(i_vertex_x) + AX_W'(ONE_Q16);
            r_ay    <= AX_W'(ONE_Q16) - AX_W'(i_vertex_y);
            r_slot1 <= p_cur;
        end
        if (s2_rdy && r_s1_vld) begin
            r_num.nx   <= n_nx;
            r_num.ny   <= n_ny;
            r_num.slot <= r_slot1;
        end
    end

    assign o_q_push = r_s2_vld;
    assign o_q_data = r_num;

endmodule

`default_nettype wire

[sv/vctc_fifo.sv]
// Short queue of remap numerators between front and back.
// Depends on vctc_pkg.
`default_nettype none

module vctc_fifo
    import vctc_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    output logic          o_full,
    input  wire t_vtx_num i_data,
    input  wire           i_pop,
    output logic          o_empty,
    output t_vtx_num      o_data
);

    t_vtx_num          r_mem [QDEPTH];
    logic [QP_W-1:0]   r_wr, r_rd;
    logic [QP_W:0]     r_cnt;
    logic              do_push, do_pop;

    always_comb begin
        o_full  = (r_cnt == (QP_W+1)'(QDEPTH));
        o_empty = (r_cnt == '0);
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rd];

endmodule

`default_nettype wire

[sv/vctc_div.sv]
// Bit-serial signed-by-unsigned floor divider, one quotient bit per cycle.
// Depends on vctc_pkg.
`default_nettype none

module vctc_div
    import vctc_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  wire signed [NUM_W-1:0] i_num,
    input  wire [DEN_W-1:0]        i_den,
    output logic                   o_done,
    output logic signed [NUM_W-1:0] o_quo
);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} t_dstate;

    t_dstate                r_state;
    logic                   r_neg;
    logic [NUM_W-1:0]       r_dvd;
    logic [DEN_W-1:0]       r_rem;
    logic [DEN_W-1:0]       r_den;
    logic [DIV_CNT_W-1:0]   r_cnt;

    logic [DEN_W:0]         trial;
    logic                   qbit;
    logic [DEN_W:0]         diff;

    always_comb begin
        trial = {r_rem, r_dvd[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_num[NUM_W-1];
                        r_dvd   <= i_num[NUM_W-1] ? -i_num : i_num;
                        r_rem   <= '0;
                        r_den   <= i_den;
                        r_cnt   <= DIV_CNT_W'(NUM_W - 1);
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    r_dvd <= {r_dvd[NUM_W-2:0], qbit};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= D_FIX;
                    end
                end
                D_FIX: begin
                    // round toward minus infinity for negative dividends
                    if (r_neg) begin
                        o_quo <= -$signed(r_dvd) - $signed(NUM_W'(r_rem != '0));
                    end else begin
                        o_quo <= $signed(r_dvd);
                    end
                    o_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/vctc_back.sv]
// Back end: divides, saturates, groups vertices into triangles, culls and
// buffers the three beats of a kept triangle. Depends on vctc_pkg, vctc_div.
`default_nettype none

module vctc_back
    import vctc_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire                     i_q_empty,
    output logic                    o_q_pop,
    input  wire t_vtx_num           i_q_data,
    output logic                    o_empty,
    input  wire                     i_pop,
    output logic signed [OUT_W-1:0] o_out_x,
    output logic signed [OUT_W-1:0] o_out_y,
    output logic                    o_last_of_triangle
);

    typedef enum logic [2:0] {B_IDLE, B_DIV, B_ADD, B_MUL, B_CMP} t_bstate;

    t_bstate                 r_state;
    logic [1:0]              r_slot;
    t_vtx                    r_v;
    t_vtx                    r_held [2];
    logic signed [OUT_W-1:0] r_lox, r_hix, r_loy, r_hiy;
    logic signed [PRD_W-1:0] r_plx, r_phx, r_ply, r_phy;
    t_vtx                    r_obuf [3];
    logic [1:0]              r_ocnt, r_ord;

    logic                    done_x, done_y;
    logic signed [NUM_W-1:0] quo_x, quo_y;
    logic                    start;
    logic signed [PRD_W-1:0] bnd_x, bnd_y;
    logic                    drop;
    logic signed [NUM_W:0]   ex, ey;
    logic signed [OUT_W-1:0] lx, hx, ly, hy;

    assign start   = (r_state == B_IDLE) && !i_q_empty;
    assign o_q_pop = start;

    vctc_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_num   (i_q_data.nx),
        .i_den   ({i_cfg.crop_w, 1'b0}),
        .o_done  (done_x),
        .o_quo   (quo_x)
    );

    vctc_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_num   (i_q_data.ny),
        .i_den   ({i_cfg.crop_h, 1'b0}),
        .o_done  (done_y),
        .o_quo   (quo_y)
    );

    always_comb begin
        ex    = (NUM_W+1)'(quo_x) - (NUM_W+1)'(ONE_Q16);
        ey    = (NUM_W+1)'(ONE_Q16) - (NUM_W+1)'(quo_y);
        bnd_x = PRD_W'({i_cfg.crop_w, 16'b0}) + PRD_W'({i_cfg.margin, 9'b0});
        bnd_y = PRD_W'({i_cfg.crop_h, 16'b0}) + PRD_W'({i_cfg.margin, 9'b0});
        drop  = (r_phx < -bnd_x) || (r_plx > bnd_x) ||
                (r_phy < -bnd_y) || (r_ply > bnd_y);
        // running box: slot zero restarts it
        if (r_slot == SLOT_FIRST) begin
            lx = r_v.x;
            hx = r_v.x;
            ly = r_v.y;
            hy = r_v.y;
        end else begin
            lx = (r_v.x < r_lox) ? r_v.x : r_lox;
            hx = (r_v.x > r_hix) ? r_v.x : r_hix;
            ly = (r_v.y < r_loy) ? r_v.y : r_loy;
            hy = (r_v.y > r_hiy) ? r_v.y : r_hiy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ocnt  <= '0;
            r_ord   <= '0;
        end else begin
            if (i_pop && !o_empty) begin
                r_ord  <= r_ord + 2'd1;
                r_ocnt <= r_ocnt - 2'd1;
            end
            case (r_state)
                B_IDLE: begin
                    if (start) begin
                        r_slot  <= i_q_data.slot;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (done_x && done_y) begin
                        r_v.x   <= sat(ex);
                        r_v.y   <= sat(ey);
                        r_state <= B_ADD;
                    end
                end
                B_ADD: begin
                    r_lox <= lx;
                    r_hix <= hx;
                    r_loy <= ly;
                    r_hiy <= hy;
                    if (r_slot == SLOT_LAST) begin
                        r_state <= B_MUL;
                    end else begin
                        r_held[r_slot[0]] <= r_v;
                        r_state           <= B_IDLE;
                    end
                end
                B_MUL: begin
                    r_plx   <= r_lox * $signed({1'b0, i_cfg.crop_w});
                    r_phx   <= r_hix * $signed({1'b0, i_cfg.crop_w});
                    r_ply   <= r_loy * $signed({1'b0, i_cfg.crop_h});
                    r_phy   <= r_hiy * $signed({1'b0, i_cfg.crop_h});
                    r_state <= B_CMP;
                end
                B_CMP: begin
                    if (drop) begin
                        r_state <= B_IDLE;
                    end else if (r_ocnt == '0) begin
                        // hold until the previous triangle has drained
                        r_obuf[0] <= r_held[0];
                        r_obuf[1] <= r_held[1];
                        r_obuf[2] <= r_v;
                        r_ocnt    <= 2'd3;
                        r_ord     <= '0;
                        r_state   <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_empty            = (r_ocnt == '0);
    assign o_out_x            = r_obuf[r_ord].x;
    assign o_out_y            = r_obuf[r_ord].y;
    assign o_last_of_triangle = (r_ord == SLOT_LAST);

endmodule

`default_nettype wire

[sv/vctc_check.sv]
// Port-level checker for the viewport crop and triangle cull block, bound to the top.
// Depends on vctc_pkg and viewport_crop_triangle_cull.
`default_nettype none

module vctc_check
    import vctc_pkg::*;
(
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    full,
    input wire                    empty,
    input wire                    pop,
    input wire signed [OUT_W-1:0] o_out_x,
    input wire signed [OUT_W-1:0] o_out_y,
    input wire                    o_last_of_triangle
);

    // Reset leaves nothing to pop and room to push.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // A waiting beat holds while not popped.
    a_beat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_x) && $stable(o_out_y)
                              && $stable(o_last_of_triangle)))
        else $error("result beat changed while waiting");

    // A triangle is delivered whole: an inner beat is always followed by another.
    a_tri_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_of_triangle) |=> !empty)
        else $error("triangle broken after inner beat");

    // The next triangle is loaded only after the last beat has drained.
    a_tri_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last_of_triangle) |=> empty)
        else $error("beat present right after last of triangle");

endmodule

bind viewport_crop_triangle_cull vctc_check u_vctc_check (.*);

`default_nettype wire
